/* design/image_rotate_nearest_neighbor_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the image rotation unit
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_NEAREST_NEIGHBOR_UNIT_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_NEIGHBOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define IROT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("irot: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define IROT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irot: assertion failed");

`else

`define IROT_ASSERT(lbl, clk, rst, prop)
`define IROT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/irot_pkg.sv */
// ----------------------------------------------------------------------------
// Image rotation package
// Sizes, register indexes, opcodes and shared types of the rotation unit.
// ----------------------------------------------------------------------------
package irot_pkg;

   // Frame store geometry.
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);

   // Field widths fixed by the interface.
   localparam int POS_W   = 9;
   localparam int PIXEL_W = 32;
   localparam int DIM_W   = 10;
   localparam int TERM_W  = 18;
   localparam int OFFS_W  = 32;

   // Arithmetic widths: products of a 10-bit signed position and an 18-bit
   // term, and the Q16.16 source coordinate with headroom for the sum.
   localparam int PROD_W  = POS_W + 1 + TERM_W;
   localparam int COORD_W = OFFS_W + 2;
   localparam int FRAC_W  = 16;
   localparam int IPART_W = COORD_W - FRAC_W;

   // Command queue between front and back.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_TERM     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_TERM     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND   = 3'd6;

   // Operation codes.
   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Mapping registers seen by the front.
   typedef struct packed {
      logic        [DIM_W-1:0]  frame_width;
      logic        [DIM_W-1:0]  frame_height;
      logic signed [TERM_W-1:0] cos_term;
      logic signed [TERM_W-1:0] sin_term;
      logic signed [OFFS_W-1:0] offset_x;
      logic signed [OFFS_W-1:0] offset_y;
   } map_cfg_type;

   // One classified command for the back.
   typedef struct packed {
      logic               is_read;
      logic               outside;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] pixel;
   } cmd_type;

endpackage

/* design/irot_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying store and request items.
// ----------------------------------------------------------------------------
interface irot_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [irot_pkg::POS_W-1:0]   column;
   logic [irot_pkg::POS_W-1:0]   row;
   logic [irot_pkg::PIXEL_W-1:0] pixel_in;

   modport source (output valid, operation, column, row, pixel_in, input ready);
   modport sink   (input valid, operation, column, row, pixel_in, output ready);
endinterface

/* design/irot_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying rotated output pixels.
// ----------------------------------------------------------------------------
interface irot_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [irot_pkg::PIXEL_W-1:0] pixel_out;
   logic                        outside;

   modport source (output valid, pixel_out, outside, input ready);
   modport sink   (input valid, pixel_out, outside, output ready);
endinterface

/* design/irot_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO that decouples the mapping front from the frame store back.
// ----------------------------------------------------------------------------
`include "image_rotate_nearest_neighbor_unit_defines.svh"

module irot_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  irot_pkg::cmd_type push_cmd,
   output logic              can_push,
   input  logic              pop,
   output irot_pkg::cmd_type head_cmd,
   output logic              head_valid
);

   irot_pkg::cmd_type                  ent_ff [irot_pkg::Q_DEPTH];
   logic [irot_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [irot_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [irot_pkg::Q_CNT_W-1:0]       count_ff, count_in;

   assign can_push   = (count_ff != irot_pkg::Q_CNT_W'(irot_pkg::Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == irot_pkg::Q_PTR_W'(irot_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == irot_pkg::Q_PTR_W'(irot_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `IROT_ASSERT(a_queue_bound, clock, reset, count_ff <= irot_pkg::Q_CNT_W'(irot_pkg::Q_DEPTH))
   `IROT_ASSERT(a_queue_no_underflow, clock, reset, !pop || head_valid)
   `IROT_ASSERT_NEXT(a_queue_grow, clock, reset, push && !pop, count_ff == irot_pkg::Q_CNT_W'($past(count_ff) + 1'b1))

endmodule

/* design/irot_front.sv */
// ----------------------------------------------------------------------------
// Mapping front
// Accepts items, maps request positions to source addresses, classifies.
// ----------------------------------------------------------------------------
`include "image_rotate_nearest_neighbor_unit_defines.svh"

module irot_front (
   input  logic                  clock,
   input  logic                  reset,
   irot_req_if.sink              req,
   input  irot_pkg::map_cfg_type cfg,
   output logic                  cmd_valid,
   output irot_pkg::cmd_type     cmd,
   input  logic                  cmd_ready
);

   logic adv;
   logic store_fits;

   // Stage A: products of position and rotation terms.
   logic                                a_valid_ff;
   logic                                a_read_ff;
   logic [irot_pkg::POS_W-1:0]          a_col_ff;
   logic [irot_pkg::POS_W-1:0]          a_row_ff;
   logic [irot_pkg::PIXEL_W-1:0]        a_pixel_ff;
   logic signed [irot_pkg::PROD_W-1:0]  a_col_cos_ff, a_row_sin_ff;
   logic signed [irot_pkg::PROD_W-1:0]  a_col_sin_ff, a_row_cos_ff;
   logic signed [irot_pkg::POS_W:0]     col_s, row_s;

   // Stage B: classified command.
   logic                                b_valid_ff;
   irot_pkg::cmd_type                   b_cmd_ff, b_cmd_in;

   logic signed [irot_pkg::COORD_W-1:0] src_x, src_y;
   logic [irot_pkg::DIM_W-1:0]          w_eff, h_eff;
   logic                                x_in, y_in;
   logic [irot_pkg::IPART_W-1:0]        sx, sy;

   assign adv        = !b_valid_ff || cmd_ready;
   assign req.ready  = adv;
   assign store_fits = (32'(req.column) < irot_pkg::MAX_WIDTH) &&
                       (32'(req.row) < irot_pkg::MAX_HEIGHT);
   assign col_s      = $signed({1'b0, req.column});
   assign row_s      = $signed({1'b0, req.row});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         // Stores that fall beyond the frame store are dropped here.
         a_valid_ff <= req.valid && (req.operation == irot_pkg::OP_REQUEST || store_fits);
         b_valid_ff <= a_valid_ff;
      end
   end

   // Both factors are sign-extended to the product width so that the full
   // product is kept.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_read_ff    <= (req.operation == irot_pkg::OP_REQUEST);
         a_col_ff     <= req.column;
         a_row_ff     <= req.row;
         a_pixel_ff   <= req.pixel_in;
         a_col_cos_ff <= irot_pkg::PROD_W'(col_s) * irot_pkg::PROD_W'(cfg.cos_term);
         a_row_sin_ff <= irot_pkg::PROD_W'(row_s) * irot_pkg::PROD_W'(cfg.sin_term);
         a_col_sin_ff <= irot_pkg::PROD_W'(col_s) * irot_pkg::PROD_W'(cfg.sin_term);
         a_row_cos_ff <= irot_pkg::PROD_W'(row_s) * irot_pkg::PROD_W'(cfg.cos_term);
         b_cmd_ff     <= b_cmd_in;
      end
   end

   always_comb begin
      w_eff = (32'(cfg.frame_width) > irot_pkg::MAX_WIDTH) ?
              irot_pkg::DIM_W'(irot_pkg::MAX_WIDTH) : cfg.frame_width;
      h_eff = (32'(cfg.frame_height) > irot_pkg::MAX_HEIGHT) ?
              irot_pkg::DIM_W'(irot_pkg::MAX_HEIGHT) : cfg.frame_height;

      src_x = irot_pkg::COORD_W'(a_col_cos_ff) - irot_pkg::COORD_W'(a_row_sin_ff) +
              irot_pkg::COORD_W'(cfg.offset_x);
      src_y = irot_pkg::COORD_W'(a_col_sin_ff) + irot_pkg::COORD_W'(a_row_cos_ff) +
              irot_pkg::COORD_W'(cfg.offset_y);

      // Truncation toward minus infinity of a nonnegative value is the integer part.
      sx   = src_x[irot_pkg::COORD_W-1:irot_pkg::FRAC_W];
      sy   = src_y[irot_pkg::COORD_W-1:irot_pkg::FRAC_W];
      x_in = !src_x[irot_pkg::COORD_W-1] && (sx < irot_pkg::IPART_W'(w_eff));
      y_in = !src_y[irot_pkg::COORD_W-1] && (sy < irot_pkg::IPART_W'(h_eff));

      b_cmd_in.is_read = a_read_ff;
      b_cmd_in.pixel   = a_pixel_ff;
      if (a_read_ff) begin
         b_cmd_in.outside = !(x_in && y_in);
         b_cmd_in.addr    = irot_pkg::ADDR_W'(sy) * irot_pkg::ADDR_W'(irot_pkg::MAX_WIDTH) +
                            irot_pkg::ADDR_W'(sx);
      end else begin
         b_cmd_in.outside = 1'b0;
         b_cmd_in.addr    = irot_pkg::ADDR_W'(a_row_ff) *
                            irot_pkg::ADDR_W'(irot_pkg::MAX_WIDTH) +
                            irot_pkg::ADDR_W'(a_col_ff);
      end
   end

   assign cmd_valid = b_valid_ff;
   assign cmd       = b_cmd_ff;

   `IROT_ASSERT_NEXT(a_front_hold, clock, reset, b_valid_ff && !cmd_ready, b_valid_ff && $stable(b_cmd_ff))

endmodule

/* design/irot_back.sv */
// ----------------------------------------------------------------------------
// Frame store back
// Executes stores and reads against the frame memory, registers results.
// ----------------------------------------------------------------------------
`include "image_rotate_nearest_neighbor_unit_defines.svh"

module irot_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  irot_pkg::cmd_type            cmd,
   output logic                         cmd_pop,
   input  logic [irot_pkg::PIXEL_W-1:0] background,
   irot_rsp_if.source                   rsp
);

   logic [irot_pkg::PIXEL_W-1:0] mem [irot_pkg::FRAME_DEPTH];

   logic                         r_valid_ff;
   logic                         r_outside_ff;
   logic [irot_pkg::PIXEL_W-1:0] rd_data_ff;

   logic                         o_valid_ff;
   logic                         o_outside_ff;
   logic [irot_pkg::PIXEL_W-1:0] o_pixel_ff;

   logic adv_o, adv_r;

   assign adv_o   = !o_valid_ff || rsp.ready;
   assign adv_r   = !r_valid_ff || adv_o;
   assign cmd_pop = cmd_valid && adv_r;

   always_ff @(posedge clock) begin
      if (cmd_pop && !cmd.is_read) begin
         mem[cmd.addr] <= cmd.pixel;
      end
      // Outside requests skip the read; their data is never used.
      if (cmd_pop && cmd.is_read && !cmd.outside) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (adv_r) begin
            r_valid_ff <= cmd_pop && cmd.is_read;
         end
         if (adv_o) begin
            o_valid_ff <= r_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_r) begin
         r_outside_ff <= cmd.outside;
      end
      if (adv_o) begin
         o_outside_ff <= r_outside_ff;
         o_pixel_ff   <= r_outside_ff ? background : rd_data_ff;
      end
   end

   assign rsp.valid     = o_valid_ff;
   assign rsp.pixel_out = o_pixel_ff;
   assign rsp.outside   = o_outside_ff;

   `IROT_ASSERT_NEXT(a_back_read_lands, clock, reset, cmd_pop && cmd.is_read, r_valid_ff)
   `IROT_ASSERT_NEXT(a_back_store_silent, clock, reset, adv_r && !(cmd_pop && cmd.is_read), !r_valid_ff)

endmodule

/* design/image_rotate_nearest_neighbor_unit.sv */
// ----------------------------------------------------------------------------
// Image rotation unit, nearest neighbor
// Rotates a true-color frame by inverse mapping into a 512 x 512 frame store.
// ----------------------------------------------------------------------------
// The unit sustains one item per clock: a store or a request enters every
// cycle while the response side keeps up. A request's result beat is offered
// once the request has passed, in order, the register at the accepting edge
// for the position times rotation terms, the offset sum and frame test, the
// command queue, the frame store read and the output register; a stall may
// hold it at any of them. Stores give no response and take effect in order, so
// a request accepted after a store sees its pixel. The frame store powers up
// undefined and is not cleared; only written entries may be read.
// The user writes configuration only while the unit is idle; the unit does not enforce this.
module image_rotate_nearest_neighbor_unit (
   input  logic                            clock,
   input  logic                            reset,
   irot_req_if.sink                        req_bus,
   irot_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [irot_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irot_pkg::CSR_DATA_W-1:0] csr_write_data
);

   irot_pkg::map_cfg_type        map_cfg_ff;
   logic [irot_pkg::PIXEL_W-1:0] background_ff;

   logic              front_valid, queue_ready;
   irot_pkg::cmd_type front_cmd;
   logic              head_valid, head_pop;
   irot_pkg::cmd_type head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cfg_ff.frame_width  <= irot_pkg::DIM_W'(512);
         map_cfg_ff.frame_height <= irot_pkg::DIM_W'(512);
         map_cfg_ff.cos_term     <= irot_pkg::TERM_W'(65536);
         map_cfg_ff.sin_term     <= '0;
         map_cfg_ff.offset_x     <= '0;
         map_cfg_ff.offset_y     <= '0;
         background_ff           <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            irot_pkg::CSR_FRAME_WIDTH: begin
               map_cfg_ff.frame_width <= csr_write_data[irot_pkg::DIM_W-1:0];
            end
            irot_pkg::CSR_FRAME_HEIGHT: begin
               map_cfg_ff.frame_height <= csr_write_data[irot_pkg::DIM_W-1:0];
            end
            irot_pkg::CSR_COS_TERM: begin
               map_cfg_ff.cos_term <= csr_write_data[irot_pkg::TERM_W-1:0];
            end
            irot_pkg::CSR_SIN_TERM: begin
               map_cfg_ff.sin_term <= csr_write_data[irot_pkg::TERM_W-1:0];
            end
            irot_pkg::CSR_OFFSET_X: begin
               map_cfg_ff.offset_x <= csr_write_data[irot_pkg::OFFS_W-1:0];
            end
            irot_pkg::CSR_OFFSET_Y: begin
               map_cfg_ff.offset_y <= csr_write_data[irot_pkg::OFFS_W-1:0];
            end
            irot_pkg::CSR_BACKGROUND: begin
               background_ff <= csr_write_data[irot_pkg::PIXEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   irot_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cfg       (map_cfg_ff),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (queue_ready)
   );

   irot_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid && queue_ready),
      .push_cmd   (front_cmd),
      .can_push   (queue_ready),
      .pop        (head_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid)
   );

   irot_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (head_pop),
      .background (background_ff),
      .rsp        (rsp_bus)
   );

endmodule
